### rtl/core/efr_pkg.sv
// Shared types, constants and codes for the escaped frame receiver.
`default_nettype none

package efr_pkg;

	// Widths fixed by the byte stream and the result fields.
	localparam int BYTE_W          = 8;
	localparam int CFG_IDX_W       = 3;
	localparam int OUT_TDATA_W     = 64;

	// Default depth of the message buffer.
	localparam int BUFFER_DEPTH_DEF = 16;

	// Stored head of a message and the checksummed lengths.
	localparam int HEAD_DEPTH   = 7;
	localparam int HEAD_IDX_W   = 3;
	localparam int DISP_SUM_LEN = 3;
	localparam int TONE_SUM_LEN = 6;
	localparam int MIN_CMD_LEN  = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MSG_START  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DISP_START = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_END        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DISP_CMD   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TONE_CMD   = 3'd5;

	// Message kind codes.
	localparam logic [1:0] KIND_DISP_RESET = 2'd0;
	localparam logic [1:0] KIND_DISP_CMD   = 2'd1;
	localparam logic [1:0] KIND_TONE       = 2'd2;
	localparam logic [1:0] KIND_UNKNOWN    = 2'd3;

	// Configuration register set.
	typedef struct packed {
		logic [BYTE_W-1:0] msg_start_code;
		logic [BYTE_W-1:0] display_start_code;
		logic [BYTE_W-1:0] end_code;
		logic [BYTE_W-1:0] escape_code;
		logic [BYTE_W-1:0] display_cmd_code;
		logic [BYTE_W-1:0] tone_cmd_code;
	} cfg_t;

	// Class of a received byte, settled by the front end.
	typedef enum logic [2:0] {
		CL_ESCAPE,
		CL_MSG_START,
		CL_DISP_START,
		CL_END,
		CL_DATA
	} byte_class_t;

	// One classified byte as it waits in the queue.
	typedef struct packed {
		byte_class_t       cls;
		logic [BYTE_W-1:0] data;
	} item_t;

	// Frame that is currently open.
	typedef enum logic [1:0] {
		FM_NONE,
		FM_MSG,
		FM_DISP
	} frame_mode_t;

	// One result; the last member sits in the lowest bit.
	typedef struct packed {
		logic        frame_event;
		logic        overflow;
		logic [15:0] tone_duration;
		logic [15:0] tone_freq;
		logic [7:0]  sender_id;
		logic        checksum_ok;
		logic [1:0]  msg_kind;
		logic        msg_valid;
		logic [7:0]  data_byte;
		logic        display_commit;
		logic        display_clear;
		logic        display_data_valid;
	} result_t;

endpackage

`default_nettype wire

### rtl/core/efr_front.sv
// Front end: tracks escapes and classifies each received byte.
`default_nettype none

module efr_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire efr_pkg::cfg_t                 cfg,
	input  wire logic                          in_valid,
	input  wire logic [efr_pkg::BYTE_W-1:0]    in_byte,
	input  wire logic                          q_ready,
	output efr_pkg::item_t                     q_item
);

	logic escape_pending_q;
	logic accept;

	assign accept = in_valid & q_ready;

	// Escape takes priority, then message start, display start and end.
	always_comb begin
		q_item.data = in_byte;
		if (!escape_pending_q && in_byte == cfg.escape_code) begin
			q_item.cls = efr_pkg::CL_ESCAPE;
		end else if (escape_pending_q) begin
			q_item.cls = efr_pkg::CL_DATA;
		end else if (in_byte == cfg.msg_start_code) begin
			q_item.cls = efr_pkg::CL_MSG_START;
		end else if (in_byte == cfg.display_start_code) begin
			q_item.cls = efr_pkg::CL_DISP_START;
		end else if (in_byte == cfg.end_code) begin
			q_item.cls = efr_pkg::CL_END;
		end else begin
			q_item.cls = efr_pkg::CL_DATA;
		end
	end

	// An escape byte marks the next byte as literal.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_pending_q <= 1'b0;
		end else if (accept) begin
			escape_pending_q <= (q_item.cls == efr_pkg::CL_ESCAPE);
		end
	end

endmodule

`default_nettype wire

### rtl/core/efr_queue.sv
// Two-entry queue of classified bytes between front and back end.
`default_nettype none

module efr_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire efr_pkg::item_t push_item,
	output logic                pop_valid,
	input  wire logic           pop_ready,
	output efr_pkg::item_t      pop_item
);

	efr_pkg::item_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic           pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign push       = push_valid & push_ready;
	assign pop        = pop_valid & pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/efr_back.sv
// Back end: frame state, message storage, decode and the output register.
`default_nettype none

module efr_back #(
	parameter int BUFFER_DEPTH = efr_pkg::BUFFER_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire efr_pkg::cfg_t  cfg,
	input  wire logic           item_valid,
	output logic                item_ready,
	input  wire efr_pkg::item_t item,
	output logic                res_valid,
	input  wire logic           res_ready,
	output efr_pkg::result_t    res
);

	localparam int IDX_W = $clog2(BUFFER_DEPTH);

	efr_pkg::frame_mode_t  mode_q, mode_d;
	logic [IDX_W-1:0]      idx_q, idx_d;
	logic [IDX_W:0]        idx_inc;
	logic [7:0]            head_q [efr_pkg::HEAD_DEPTH];
	logic [7:0]            hb [efr_pkg::HEAD_DEPTH];
	logic [7:0]            sum3_q, sum3_d;
	logic [7:0]            sum6_q, sum6_d;
	logic                  head_we;
	efr_pkg::result_t      res_d;
	logic                  pop;

	assign item_ready = ~res_valid | res_ready;
	assign pop        = item_valid & item_ready;
	assign idx_inc    = {1'b0, idx_q} + {{IDX_W{1'b0}}, 1'b1};

	// Stored bytes read as zero at and above the fill index.
	always_comb begin
		for (int i = 0; i < efr_pkg::HEAD_DEPTH; i++) begin
			hb[i] = ({1'b0, idx_q} > (IDX_W+1)'(i)) ? head_q[i] : 8'd0;
		end
	end

	// Next frame state and the result of the byte at the queue head.
	always_comb begin
		mode_d  = mode_q;
		idx_d   = idx_q;
		sum3_d  = sum3_q;
		sum6_d  = sum6_q;
		head_we = 1'b0;
		res_d   = '0;
		case (item.cls)
			efr_pkg::CL_ESCAPE: begin
				res_d = '0;
			end
			efr_pkg::CL_MSG_START: begin
				mode_d = efr_pkg::FM_MSG;
				idx_d  = '0;
				sum3_d = '0;
				sum6_d = '0;
			end
			efr_pkg::CL_DISP_START: begin
				mode_d              = efr_pkg::FM_DISP;
				res_d.display_clear = 1'b1;
			end
			efr_pkg::CL_END: begin
				res_d.frame_event = 1'b1;
				if (mode_q == efr_pkg::FM_MSG) begin
					res_d.msg_valid = 1'b1;
					res_d.sender_id = hb[0];
					res_d.msg_kind  = efr_pkg::KIND_UNKNOWN;
					if (idx_q >= IDX_W'(efr_pkg::MIN_CMD_LEN) && hb[1] == cfg.display_cmd_code) begin
						res_d.msg_kind    = (hb[2] == 8'd0) ? efr_pkg::KIND_DISP_RESET
						                                    : efr_pkg::KIND_DISP_CMD;
						res_d.checksum_ok = (idx_q >= IDX_W'(efr_pkg::DISP_SUM_LEN + 1))
						                    && (sum3_q == hb[3]);
						res_d.data_byte   = hb[2];
					end else if (idx_q >= IDX_W'(efr_pkg::MIN_CMD_LEN)
					             && hb[1] == cfg.tone_cmd_code) begin
						res_d.msg_kind      = efr_pkg::KIND_TONE;
						res_d.checksum_ok   = (idx_q >= IDX_W'(efr_pkg::TONE_SUM_LEN + 1))
						                      && (sum6_q == hb[6]);
						res_d.tone_freq     = {hb[2], hb[3]};
						res_d.tone_duration = {hb[4], hb[5]};
					end
					idx_d  = '0;
					sum3_d = '0;
					sum6_d = '0;
				end else if (mode_q == efr_pkg::FM_DISP) begin
					res_d.display_commit = 1'b1;
				end
				mode_d = efr_pkg::FM_NONE;
			end
			default: begin
				if (mode_q == efr_pkg::FM_DISP) begin
					res_d.display_data_valid = 1'b1;
					res_d.data_byte          = item.data;
				end else if (mode_q == efr_pkg::FM_MSG) begin
					head_we = (idx_q < IDX_W'(efr_pkg::HEAD_DEPTH));
					if (idx_q < IDX_W'(efr_pkg::DISP_SUM_LEN)) begin
						sum3_d = sum3_q + item.data;
					end
					if (idx_q < IDX_W'(efr_pkg::TONE_SUM_LEN)) begin
						sum6_d = sum6_q + item.data;
					end
					idx_d = idx_inc[IDX_W-1:0];
					// Buffer full: abort the frame.
					if (idx_inc >= (IDX_W+1)'(BUFFER_DEPTH)) begin
						idx_d             = '0;
						sum3_d            = '0;
						sum6_d            = '0;
						mode_d            = efr_pkg::FM_NONE;
						res_d.overflow    = 1'b1;
						res_d.frame_event = 1'b1;
					end
				end
			end
		endcase
	end

	// Message head storage.
	always_ff @(posedge clk) begin
		if (pop && head_we) begin
			head_q[idx_q[efr_pkg::HEAD_IDX_W-1:0]] <= item.data;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (pop) begin
			res <= res_d;
		end
	end

	// Frame state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= efr_pkg::FM_NONE;
			idx_q     <= '0;
			sum3_q    <= '0;
			sum6_q    <= '0;
			res_valid <= 1'b0;
		end else begin
			if (pop) begin
				mode_q <= mode_d;
				idx_q  <= idx_d;
				sum3_q <= sum3_d;
				sum6_q <= sum6_d;
			end
			if (item_ready) begin
				res_valid <= item_valid;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/escaped_frame_receiver_unit.sv
// Top level of the escaped frame receiver: configuration registers and stream ports.
//
//   Channel   Direction  Payload
//   s_*       in         s_tdata[7:0] rx_byte
//   m_*       out        m_tdata[56:0] result fields, one result per received byte
//   cfg_*     in         cfg_index selects a register, cfg_data[7:0] its value
//
// An input transfer is classified and written into the queue at its clock edge; the
// back end takes it from the queue head and registers its result, so between input
// and result lie the queue entry and the result register. One byte is accepted every
// cycle while the output does not stall; the back end decodes a message in the same
// cycle as its end byte. While the output stalls, the two-entry queue fills and then
// holds off the input. Reset opens no frame; no clearing pass is needed.
`default_nettype none

module escaped_frame_receiver_unit #(
	parameter int BUFFER_DEPTH = efr_pkg::BUFFER_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Received byte stream: rx_byte [7:0].
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [efr_pkg::BYTE_W-1:0]       s_tdata,
	// Result stream: display_data_valid [0], display_clear [1], display_commit [2],
	// data_byte [10:3], msg_valid [11], msg_kind [13:12], checksum_ok [14],
	// sender_id [22:15], tone_freq [38:23], tone_duration [54:39], overflow [55],
	// frame_event [56], zero fill [63:57].
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [efr_pkg::OUT_TDATA_W-1:0]       m_tdata,
	// Configuration writes.
	input  wire logic                             cfg_we,
	input  wire logic [efr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [efr_pkg::BYTE_W-1:0]       cfg_data
);

	efr_pkg::cfg_t    cfg_q;
	efr_pkg::item_t   front_item;
	efr_pkg::item_t   back_item;
	logic             back_valid;
	logic             back_ready;
	efr_pkg::result_t res;

	// Configuration registers; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.msg_start_code     <= 8'd2;
			cfg_q.display_start_code <= 8'd18;
			cfg_q.end_code           <= 8'd3;
			cfg_q.escape_code        <= 8'd27;
			cfg_q.display_cmd_code   <= 8'd1;
			cfg_q.tone_cmd_code      <= 8'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				efr_pkg::CFG_MSG_START:  cfg_q.msg_start_code     <= cfg_data;
				efr_pkg::CFG_DISP_START: cfg_q.display_start_code <= cfg_data;
				efr_pkg::CFG_END:        cfg_q.end_code           <= cfg_data;
				efr_pkg::CFG_ESCAPE:     cfg_q.escape_code        <= cfg_data;
				efr_pkg::CFG_DISP_CMD:   cfg_q.display_cmd_code   <= cfg_data;
				efr_pkg::CFG_TONE_CMD:   cfg_q.tone_cmd_code      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Escape tracking and byte classification.
	efr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_byte  (s_tdata),
		.q_ready  (s_tready),
		.q_item   (front_item)
	);

	// Queue between the two ends.
	efr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (s_tvalid),
		.push_ready (s_tready),
		.push_item  (front_item),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_item   (back_item)
	);

	// Frame handling and message decode.
	efr_back #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (back_valid),
		.item_ready (back_ready),
		.item       (back_item),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res        (res)
	);

	// Result fields packed from the lowest bit, zero filled to whole bytes.
	assign m_tdata = {{(efr_pkg::OUT_TDATA_W - $bits(efr_pkg::result_t)){1'b0}}, res};

endmodule

`default_nettype wire
